// ----- rtl/hcr_pkg.sv -----
package hcr_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int WINDOW       = 3;
    localparam int GRAD_BITS    = 12;
    localparam int WIN_CELLS    = WINDOW * WINDOW;
    localparam int COL_BITS     = 10;
    localparam int ROW_BITS     = 16;
    localparam int WIDTH_BITS   = 11;
    localparam int LINE_BITS    = GRAD_BITS * (WINDOW - 1);
    localparam int SXX_BITS     = 26;
    localparam int SXY_BITS     = 27;
    localparam int PROD_BITS    = 2 * SXX_BITS;
    localparam int DIVIDEND_BITS = PROD_BITS + 1;
    localparam int TRACE_BITS   = SXX_BITS + 1;
    localparam int RESP_BITS    = 26;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_BITS    = 1;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [ROW_BITS-1:0]   HEIGHT_RESET = 16'd480;

    typedef struct packed {
        logic signed [GRAD_BITS-1:0] grad_x;
        logic signed [GRAD_BITS-1:0] grad_y;
    } t_pixel;

    typedef struct packed {
        logic [RESP_BITS-1:0] response;
        logic                 frame_end;
    } t_result;

    typedef struct packed {
        logic [SXX_BITS-1:0]        sxx;
        logic signed [SXY_BITS-1:0] sxy;
        logic [SXX_BITS-1:0]        syy;
        logic                       frame_end;
    } t_sums;

    typedef enum logic [2:0] {
        F_IDLE,
        F_READ,
        F_SHIFT,
        F_SUM,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_SUB,
        B_DIV,
        B_OUT
    } t_back_state;

endpackage

// ----- rtl/harris_corner_response.sv -----
// Harris-Noble corner response, 3x3 window, over a raster stream of x/y gradient
// pixels. One result per interior pixel: floor(2*det/trace) of the window that
// ends at that pixel (0 for an all-zero window), with frame_end on the frame's
// last result. Interior pixels take 9 multiply-accumulate steps over the window
// in the front end; the back end computes each result with a one-bit-per-cycle
// 53-step divider, which bounds sustained throughput for interior pixels. A
// 2-entry queue between the two ends lets them stall independently. Line
// buffers are not cleared after reset; write image_width and image_height only
// while idle.
module harris_corner_response (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  hcr_pkg::t_pixel                        i_data,
    output logic                                   empty,
    input  logic                                   pop,
    output hcr_pkg::t_result                       o_result,
    input  logic                                   i_cfg_we,
    input  logic [hcr_pkg::CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [hcr_pkg::CFG_DATA_BITS-1:0]      i_cfg_data
);
    import hcr_pkg::*;

    logic [WIDTH_BITS-1:0] r_image_width;
    logic [ROW_BITS-1:0]   r_image_height;
    logic [COL_BITS-1:0]   last_col;
    logic [ROW_BITS-1:0]   last_row;
    logic                  q_push, q_full, q_pop, q_empty;
    t_sums                 q_in, q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= WIDTH_RESET;
            r_image_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[WIDTH_BITS-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp geometry to what the line buffers support
    always_comb begin
        if (r_image_width < 11'd3)            last_col = 10'd2;
        else if (r_image_width > 11'd1024)    last_col = 10'd1023;
        else                                  last_col = 10'(r_image_width - 1'b1);
        if (r_image_height < 16'd3)           last_row = 16'd2;
        else                                  last_row = r_image_height - 1'b1;
    end

    hcr_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_data(i_data),
        .i_last_col(last_col), .i_last_row(last_row),
        .o_q_push(q_push), .i_q_full(q_full), .o_sums(q_in)
    );

    hcr_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(q_push), .i_data(q_in), .o_full(q_full),
        .i_pop(q_pop), .o_data(q_out), .o_empty(q_empty)
    );

    hcr_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_empty(q_empty), .i_sums(q_out),
        .o_q_pop(q_pop), .empty(empty), .pop(pop), .o_result(o_result)
    );
endmodule

// ----- rtl/hcr_ram.sv -----
module hcr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/hcr_front.sv -----
module hcr_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  hcr_pkg::t_pixel        i_data,
    input  logic [9:0]             i_last_col,
    input  logic [15:0]            i_last_row,
    output logic                   o_q_push,
    input  logic                   i_q_full,
    output hcr_pkg::t_sums         o_sums
);
    import hcr_pkg::*;

    t_front_state r_state, n_state;
    logic [COL_BITS-1:0] r_col, n_col;
    logic [ROW_BITS-1:0] r_row, n_row;
    logic [COL_BITS-1:0] r_idx;
    logic                r_emit, r_fend;
    logic signed [GRAD_BITS-1:0] r_gx, r_gy;
    logic signed [GRAD_BITS-1:0] r_win_x [WIN_CELLS];
    logic signed [GRAD_BITS-1:0] r_win_y [WIN_CELLS];
    logic [3:0]          r_cnt;
    logic [SXX_BITS-1:0] r_sxx, r_syy;
    logic signed [SXY_BITS-1:0] r_sxy;
    logic [LINE_BITS-1:0] line_x, line_y;
    logic                accept, ram_we;
    logic signed [2*GRAD_BITS-1:0] p_xx, p_xy, p_yy;

    assign accept = push && !full;

    hcr_ram #(.WIDTH(LINE_BITS), .DEPTH(MAX_WIDTH)) u_lines_x (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(r_idx),
        .i_wdata({r_gx, line_x[2*GRAD_BITS-1:GRAD_BITS]}),
        .i_raddr(r_idx), .o_rdata(line_x)
    );
    hcr_ram #(.WIDTH(LINE_BITS), .DEPTH(MAX_WIDTH)) u_lines_y (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(r_idx),
        .i_wdata({r_gy, line_y[2*GRAD_BITS-1:GRAD_BITS]}),
        .i_raddr(r_idx), .o_rdata(line_y)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE:  if (accept) n_state = F_READ;
            F_READ:  n_state = F_SHIFT;
            F_SHIFT: n_state = r_emit ? F_SUM : F_IDLE;
            F_SUM:   if (r_cnt == 4'(WIN_CELLS - 1)) n_state = F_PUSH;
            F_PUSH:  if (!i_q_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        full     = (r_state != F_IDLE);
        ram_we   = (r_state == F_SHIFT);
        o_q_push = (r_state == F_PUSH) && !i_q_full;
        o_sums   = '{sxx: r_sxx, sxy: r_sxy, syy: r_syy, frame_end: r_fend};
    end

    // advance raster position
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (r_col >= i_last_col) begin
            n_col = '0;
            n_row = (r_row >= i_last_row) ? '0 : r_row + 1'b1;
        end else begin
            n_col = r_col + 1'b1;
        end
    end

    assign p_xx = r_win_x[r_cnt] * r_win_x[r_cnt];
    assign p_xy = r_win_x[r_cnt] * r_win_y[r_cnt];
    assign p_yy = r_win_y[r_cnt] * r_win_y[r_cnt];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            for (int i = 0; i < WIN_CELLS; i++) begin
                r_win_x[i] <= '0;
                r_win_y[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (r_state == F_SHIFT) begin
                for (int r = 0; r < WINDOW; r++) begin
                    for (int c = 0; c < WINDOW - 1; c++) begin
                        r_win_x[r*WINDOW+c] <= r_win_x[r*WINDOW+c+1];
                        r_win_y[r*WINDOW+c] <= r_win_y[r*WINDOW+c+1];
                    end
                end
                r_win_x[WINDOW-1]        <= line_x[GRAD_BITS-1:0];
                r_win_y[WINDOW-1]        <= line_y[GRAD_BITS-1:0];
                r_win_x[2*WINDOW-1]      <= line_x[2*GRAD_BITS-1:GRAD_BITS];
                r_win_y[2*WINDOW-1]      <= line_y[2*GRAD_BITS-1:GRAD_BITS];
                r_win_x[WIN_CELLS-1]     <= r_gx;
                r_win_y[WIN_CELLS-1]     <= r_gy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_gx   <= i_data.grad_x;
            r_gy   <= i_data.grad_y;
            r_idx  <= r_col;
            r_emit <= (r_row >= 16'd2) && (r_col >= 10'd2);
            r_fend <= (r_row == i_last_row) && (r_col == i_last_col);
        end
        if (r_state == F_SHIFT) begin
            r_cnt <= '0;
            r_sxx <= '0;
            r_sxy <= '0;
            r_syy <= '0;
        end else if (r_state == F_SUM) begin
            r_cnt <= r_cnt + 1'b1;
            r_sxx <= r_sxx + {3'b000, p_xx[22:0]};
            r_sxy <= r_sxy + {{3{p_xy[23]}}, p_xy};
            r_syy <= r_syy + {3'b000, p_yy[22:0]};
        end
    end

    a_sum_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_SUM) |-> (r_emit && r_cnt < 4'(WIN_CELLS)))
        else $error("sum pass without a full window");
endmodule

// ----- rtl/hcr_queue.sv -----
module hcr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hcr_pkg::t_sums i_data,
    output logic           o_full,
    input  logic           i_pop,
    output hcr_pkg::t_sums o_data,
    output logic           o_empty
);
    import hcr_pkg::*;

    t_sums r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wptr, r_rptr;
    logic [QPTR_BITS:0]   r_count;

    assign o_full  = (r_count == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + 1'b1;
            if (i_pop)  r_rptr <= r_rptr + 1'b1;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (i_pop && !i_push) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_data;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue underflow");
endmodule

// ----- rtl/hcr_back.sv -----
module hcr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  hcr_pkg::t_sums  i_sums,
    output logic            o_q_pop,
    output logic            empty,
    input  logic            pop,
    output hcr_pkg::t_result o_result
);
    import hcr_pkg::*;

    localparam logic [5:0] LAST_STEP = 6'(DIVIDEND_BITS - 1);

    t_back_state r_state, n_state;
    t_sums       r_sums;
    logic [PROD_BITS-1:0]     r_p1, r_p2;
    logic [TRACE_BITS-1:0]    r_trace;
    logic [TRACE_BITS-1:0]    r_rem;
    logic [DIVIDEND_BITS-1:0] r_quo;
    logic [5:0]               r_cnt;
    logic                     r_out_valid;
    t_result                  r_result;
    logic [SXY_BITS-1:0]      neg_sxy;
    logic [SXX_BITS-1:0]      mag_sxy;
    logic [TRACE_BITS:0]      shifted;
    logic [TRACE_BITS:0]      diff;
    logic                     fits, out_free, load_out;
    logic [TRACE_BITS-1:0]    trace;

    assign neg_sxy  = -r_sums.sxy;
    assign mag_sxy  = r_sums.sxy[SXY_BITS-1] ? neg_sxy[SXX_BITS-1:0]
                                             : r_sums.sxy[SXX_BITS-1:0];
    assign trace    = {1'b0, r_sums.sxx} + {1'b0, r_sums.syy};
    assign shifted  = {r_rem, r_quo[DIVIDEND_BITS-1]};
    assign diff     = shifted - {1'b0, r_trace};
    assign fits     = shifted >= {1'b0, r_trace};
    assign out_free = !r_out_valid || pop;
    assign load_out = (r_state == B_OUT) && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE:  if (!i_q_empty) n_state = B_MUL;
            B_MUL:   n_state = B_SUB;
            B_SUB:   n_state = (trace == '0) ? B_OUT : B_DIV;
            B_DIV:   if (r_cnt == '0) n_state = B_OUT;
            B_OUT:   if (out_free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop  = (r_state == B_IDLE) && !i_q_empty;
        empty    = !r_out_valid;
        o_result = r_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out)   r_out_valid <= 1'b1;
            else if (pop)   r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_sums <= i_sums;
        if (r_state == B_MUL) begin
            r_p1 <= r_sums.sxx * r_sums.syy;
            r_p2 <= mag_sxy * mag_sxy;
        end
        if (r_state == B_SUB) begin
            r_trace <= trace;
            r_rem   <= '0;
            r_cnt   <= LAST_STEP;
            // zero trace: quotient reads as 0
            r_quo   <= (trace == '0) ? '0 : {r_p1 - r_p2, 1'b0};
        end else if (r_state == B_DIV) begin
            r_cnt <= r_cnt - 1'b1;
            r_rem <= fits ? diff[TRACE_BITS-1:0] : shifted[TRACE_BITS-1:0];
            r_quo <= {r_quo[DIVIDEND_BITS-2:0], fits};
        end
        if (load_out) begin
            r_result.response  <= r_quo[RESP_BITS-1:0];
            r_result.frame_end <= r_sums.frame_end;
        end
    end

    a_trace_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DIV) |-> (r_trace != '0))
        else $error("division by zero trace");
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !pop) |=> (r_out_valid && $stable(r_result)))
        else $error("pending result lost");
endmodule
